@@ rtl/core/mssa_pkg.sv @@
// ----------------------------------------------------------------------------
// mssa_pkg
// Shared types and constants of the multi-stack shared array.
// ----------------------------------------------------------------------------
package mssa_pkg;

    localparam int CAP_W   = 7;
    localparam int NSTK_W  = 4;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd10;
    localparam logic [NSTK_W-1:0] NSTK_RESET = 4'd1;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_CAPACITY   = 1'b0,
        REG_NUM_STACKS = 1'b1
    } reg_idx_t;

endpackage

@@ rtl/core/mssa_div.sv @@
// ----------------------------------------------------------------------------
// mssa_div
// Restoring divider, one quotient bit per cycle, for the per-stack size.
// ----------------------------------------------------------------------------
module mssa_div import mssa_pkg::*; #(
    parameter int PW = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PW-1:0]     dividend,
    input  logic [NSTK_W-1:0] divisor,
    output logic              busy,
    output logic [PW-1:0]     quotient
);

    localparam int CW = $clog2(PW + 1);

    logic [CW-1:0]     count_reg, count_next;
    logic [PW-1:0]     quo_reg, quo_next;
    logic [NSTK_W-1:0] rem_reg, rem_next;
    logic [NSTK_W-1:0] div_reg, div_next;
    logic [NSTK_W:0]   trial;

    always_comb begin
        trial      = {rem_reg, quo_reg[PW-1]};
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start) begin
            count_next = CW'(PW);
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end else if (count_reg != '0) begin
            count_next = count_reg - 1'b1;
            if (trial >= {1'b0, div_reg}) begin
                rem_next = NSTK_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[PW-2:0], 1'b1};
            end else begin
                rem_next = trial[NSTK_W-1:0];
                quo_next = {quo_reg[PW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = quo_reg;

endmodule

@@ rtl/core/mssa_mem.sv @@
// ----------------------------------------------------------------------------
// mssa_mem
// Stack data memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mssa_mem import mssa_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/multi_stack_shared_array.sv @@
// ----------------------------------------------------------------------------
// multi_stack_shared_array
// Stacks sharing one data memory in equal configured slots, rest to the last.
// ----------------------------------------------------------------------------
// One push or pop request is taken per cycle and answered with one result
// word; the result leaves from the memory read register, so a new request
// is taken while m_tready is high or no result is pending. The top pointers
// sit in a small register file updated in the same cycle as the request,
// so back-to-back requests on one stack need no stall. After reset and
// after every configuration write the block rebuilds the per-stack size
// with a bit-serial divider and takes no request until the divider is done;
// all stacks are empty afterwards.
// ----------------------------------------------------------------------------
module multi_stack_shared_array import mssa_pkg::*; #(
    parameter int MEM_DEPTH  = 64,
    parameter int MAX_STACKS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,   // push_value
    input  logic [IDX_W:0]     s_tuser,   // op, stack_index
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,   // pop_value
    output logic [1:0]         m_tuser,   // status
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int PW = $clog2(MEM_DEPTH + 1);
    localparam int SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int MW = PW + IDX_W + 1;

    logic [CAP_W-1:0]  cap_reg;
    logic [NSTK_W-1:0] nstk_reg;
    logic              start_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_sel;

    logic [PW-1:0]     eff_cap;
    logic [NSTK_W-1:0] eff_n;
    logic              div_busy;
    logic [PW-1:0]     slot;

    logic [PW-1:0]     ptr_reg [MAX_STACKS];
    logic [MAX_STACKS-1:0] ptr_valid_reg;

    logic              m_valid_reg;
    status_t           status_reg, status_next;
    logic              pop_ok_reg;

    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [SW-1:0]     isel;
    logic              accept;
    logic              in_range;
    logic [MW-1:0]     base_wide;
    logic [MW-1:0]     lim_wide;
    logic [PW-1:0]     base;
    logic [PW-1:0]     limit;
    logic [PW-1:0]     top;
    logic [PW-1:0]     ptr_next;
    logic              ptr_we;
    logic              mem_we;
    logic              mem_re;
    logic [DATA_W-1:0] mem_rdata;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_sel = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_comb begin
        unique case (cfg_sel)
            REG_CAPACITY:   prdata = PDATA_W'(cap_reg);
            REG_NUM_STACKS: prdata = PDATA_W'(nstk_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET;
            nstk_reg  <= NSTK_RESET;
            start_reg <= 1'b1;
        end else begin
            start_reg <= cfg_wr;
            if (cfg_wr) begin
                unique case (cfg_sel)
                    REG_CAPACITY:   cap_reg  <= pwdata[CAP_W-1:0];
                    REG_NUM_STACKS: nstk_reg <= pwdata[NSTK_W-1:0];
                    default:        cap_reg  <= cap_reg;
                endcase
            end
        end
    end

    // clamp configuration to the supported range
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = PW'(1);
        end else if (int'(cap_reg) > MEM_DEPTH) begin
            eff_cap = PW'(MEM_DEPTH);
        end else begin
            eff_cap = PW'(cap_reg);
        end
        if (nstk_reg == '0) begin
            eff_n = NSTK_W'(1);
        end else if (int'(nstk_reg) > MAX_STACKS) begin
            eff_n = NSTK_W'(MAX_STACKS);
        end else begin
            eff_n = nstk_reg;
        end
    end

    mssa_div #(
        .PW(PW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (eff_cap),
        .divisor  (eff_n),
        .busy     (div_busy),
        .quotient (slot)
    );

    // request decode
    assign op       = op_t'(s_tuser[0]);
    assign idx      = s_tuser[IDX_W:1];
    assign isel     = SW'(idx);
    assign s_tready = !start_reg && !div_busy && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign in_range = ({1'b0, idx} < eff_n);

    assign base_wide = MW'(idx) * MW'(slot);
    assign lim_wide  = base_wide + MW'(slot);
    assign base      = base_wide[PW-1:0];

    always_comb begin
        if ((MW'(idx) + MW'(1)) < MW'(eff_n)) begin
            limit = lim_wide[PW-1:0];
        end else begin
            limit = eff_cap;
        end
        top = ptr_valid_reg[isel] ? ptr_reg[isel] : base;
    end

    always_comb begin
        status_next = ST_OK;
        ptr_next    = top;
        ptr_we      = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        priority if (!in_range) begin
            status_next = ST_RANGE;
        end else if (op == OP_PUSH) begin
            if (top >= limit) begin
                status_next = ST_FULL;
            end else begin
                ptr_next = top + 1'b1;
                ptr_we   = accept;
                mem_we   = accept;
            end
        end else begin
            if (top <= base) begin
                status_next = ST_EMPTY;
            end else begin
                ptr_next = top - 1'b1;
                ptr_we   = accept;
                mem_re   = accept;
            end
        end
    end

    // top pointer file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_valid_reg <= '0;
        end else if (cfg_wr) begin
            ptr_valid_reg <= '0;
        end else if (ptr_we) begin
            ptr_valid_reg[isel] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ptr_we) begin
            ptr_reg[isel] <= ptr_next;
        end
    end

    mssa_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (top[AW-1:0]),
        .wdata (s_tdata),
        .re    (mem_re),
        .raddr (ptr_next[AW-1:0]),
        .rdata (mem_rdata)
    );

    // result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            pop_ok_reg <= mem_re;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = pop_ok_reg ? mem_rdata : '0;

endmodule

@@ tb/sv/multi_stack_shared_array_tb.sv @@
// ----------------------------------------------------------------------------
// multi_stack_shared_array_tb
// Self-checking bench for the multi-stack shared array.
// ----------------------------------------------------------------------------
// Push and pop requests go in on the request stream. A behavioral copy of the
// stacks predicts the status and popped word of each request, and every
// result word is compared with the oldest prediction. The run covers the
// reset layout with directed requests, then a long receiver hold-off, then a
// sweep over capacity and stack-count settings (out-of-range values among
// them) with random push/pop bursts that drive stacks to full and to empty.
// Both stream sides insert random idle cycles.
// ----------------------------------------------------------------------------
module multi_stack_shared_array_tb;
    import mssa_pkg::*;

    localparam int MEM_DEPTH   = 64;
    localparam int MAX_STACKS  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT_TIME  = 3_000_000;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] value;
    } stack_result_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata  = '0;  // push_value
    logic [IDX_W:0]     s_tuser  = '0;  // op, stack_index
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [DATA_W-1:0]  m_tdata;        // pop_value
    logic [1:0]         m_tuser;        // status
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic [CAP_W-1:0]   cfg_capacity;
    logic [NSTK_W-1:0]  cfg_stacks;
    int                 base_word [MAX_STACKS];
    int                 top_word  [MAX_STACKS];
    logic [DATA_W-1:0]  mem_words [MEM_DEPTH];

    stack_result_t      result_q[$];
    int unsigned        err_count;
    bit                 idle_on;
    bit                 hold_req;

    multi_stack_shared_array #(
        .MEM_DEPTH  (MEM_DEPTH),
        .MAX_STACKS (MAX_STACKS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int eff_capacity();
        int c;
        c = int'(cfg_capacity);
        if (c < 1) c = 1;
        if (c > MEM_DEPTH) c = MEM_DEPTH;
        return c;
    endfunction

    function automatic int eff_stacks();
        int n;
        n = int'(cfg_stacks);
        if (n < 1) n = 1;
        if (n > MAX_STACKS) n = MAX_STACKS;
        return n;
    endfunction

    function automatic void rebuild_slots();
        int n;
        int slot;
        n    = eff_stacks();
        slot = eff_capacity() / n;
        for (int k = 0; k < MAX_STACKS; k++) begin
            base_word[k] = (k < n) ? slot * k : 0;
            top_word[k]  = base_word[k];
        end
    endfunction

    function automatic stack_result_t predict_request(input op_t op,
                                                      input logic [IDX_W-1:0] idx,
                                                      input logic [DATA_W-1:0] val);
        stack_result_t r;
        int            i;
        int            n;
        int            lim;
        int            t;
        i        = int'(idx);
        n        = eff_stacks();
        r.status = ST_OK;
        r.value  = '0;
        t        = top_word[i];
        if (i >= n) begin
            r.status = ST_RANGE;
        end else if (op == OP_PUSH) begin
            lim = (i + 1 < n) ? base_word[i + 1] : eff_capacity();
            if (t >= lim || t >= MEM_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                mem_words[t] = val;
                top_word[i]  = t + 1;
            end
        end else begin
            if (t <= base_word[i] || t > MEM_DEPTH) begin
                r.status = ST_EMPTY;
            end else begin
                r.value     = mem_words[t - 1];
                top_word[i] = t - 1;
            end
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                                input logic [DATA_W-1:0] act_v);
        err_count++;
        if (err_count <= 10) begin
            $display("mismatch %s: expected %08h got %08h", what, exp_v, act_v);
        end
    endtask

    // request stream
    task automatic send_request(input op_t op, input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] val);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= val;
        s_tuser  <= {idx, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        result_q.push_back(predict_request(op, idx, val));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (result_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [PDATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(r) << 2;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_CAPACITY) cfg_capacity = v[CAP_W-1:0];
        else cfg_stacks = v[NSTK_W-1:0];
        rebuild_slots();
        @(posedge aclk);
    endtask

    task automatic run_random_mix(input int count);
        int          left;
        int          burst;
        int unsigned push_pct;
        bit          fill_phase;
        op_t         op;
        logic [2:0]  idx;
        left       = count;
        fill_phase = 1'b1;
        while (left > 0) begin
            burst    = $urandom_range(6, 24);
            push_pct = fill_phase ? 80 : 20;
            idle_on  = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < burst && left > 0; k++) begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                if ($urandom_range(0, 99) < 85) idx = 3'($urandom_range(0, eff_stacks() - 1));
                else idx = 3'($urandom_range(0, 7));
                send_request(op, idx, $urandom());
                left--;
            end
            fill_phase = !fill_phase;
        end
    endtask

    task automatic test_directed_ops();
        idle_on = 1'b1;
        send_request(OP_POP, 3'd0, 32'h1234_5678);
        send_request(OP_PUSH, 3'd0, 32'h8000_0000);
        send_request(OP_PUSH, 3'd0, 32'h7FFF_FFFF);
        send_request(OP_PUSH, 3'd0, 32'h0000_0000);
        send_request(OP_PUSH, 3'd0, 32'hFFFF_FFFF);
        repeat (4) send_request(OP_POP, 3'd0, $urandom());
        send_request(OP_PUSH, 3'd1, 32'hA5A5_A5A5);
        send_request(OP_POP, 3'd7, 32'h5A5A_5A5A);
        for (int k = 0; k < 11; k++) send_request(OP_PUSH, 3'd0, $urandom());
        send_request(OP_POP, 3'd0, 32'h0);
        drain_results();
    endtask

    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_request(($urandom_range(0, 1) != 0) ? OP_PUSH : OP_POP, 3'd0, $urandom());
        end
        drain_results();
    endtask

    task automatic test_config_sweep();
        int unsigned caps [10];
        int unsigned cnts [10];
        caps = '{64, 1, 0, 127, 5, 64, 13, 7, 100, 10};
        cnts = '{8, 1, 0, 15, 8, 3, 5, 2, 9, 1};
        for (int s = 0; s < 10; s++) begin
            write_reg(REG_CAPACITY, caps[s]);
            write_reg(REG_NUM_STACKS, cnts[s]);
            run_random_mix(105);
            drain_results();
        end
    endtask

    // result stream: random stalls, one long hold-off on request
    initial begin
        int unsigned stall;
        forever begin
            stall = idle_on ? $urandom_range(0, 16) : 0;
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                log_mismatch("unexpected word", '0, m_tdata);
            end else begin
                if (m_tuser != result_q[0].status) begin
                    log_mismatch("status", DATA_W'(result_q[0].status), DATA_W'(m_tuser));
                end
                if (m_tdata != result_q[0].value) begin
                    log_mismatch("pop_value", result_q[0].value, m_tdata);
                end
                void'(result_q.pop_front());
            end
        end
    end

    initial begin
        #(LIMIT_TIME);
        $display("simulation failed");
        $finish;
    end

    initial begin
        err_count    = 0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        cfg_capacity = CAP_RESET;
        cfg_stacks   = NSTK_RESET;
        rebuild_slots();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_ops();
        test_backpressure();
        test_config_sweep();
        drain_results();
        repeat (20) @(posedge aclk);
        err_count += result_q.size();
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
